@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/eet_pkg.sv @@
// types and constants of the expiring event table
`default_nettype none
package eet_pkg;

  localparam int unsigned IN_W  = 272;
  localparam int unsigned OUT_W = 296;
  localparam int unsigned QW    = 12;

  localparam logic [QW-1:0] PENALTY_NUM = 12'd3277;
  localparam logic [16:0]   URG_ONE     = 17'd65536;
  localparam logic [4:0]    MAX_RES     = 5'd16;
  localparam logic [31:0]   LIFE_RESET  = 32'd180;
  localparam logic [30:0]   PREC_RESET  = 31'd65536;

  // register indexes
  localparam logic REG_LIFETIME = 1'b0;
  localparam logic REG_MIN_PREC = 1'b1;

  // action codes
  localparam logic ACT_PUBLISH = 1'b0;
  localparam logic ACT_COLLECT = 1'b1;

  // input item, first field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  collect_limit;
    logic [47:0] expiry;
    logic [47:0] tick;
    logic [17:0] urgency;
    logic [31:0] precision;
    logic [47:0] position;
    logic [31:0] subject;
    logic [31:0] sender;
    logic [3:0]  kind;
  } in_item_t;

  // result item, first field in the lowest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic [47:0] expiry_out;
    logic [47:0] issued_out;
    logic [16:0] urgency_out;
    logic [30:0] precision_out;
    logic [47:0] position_out;
    logic [31:0] subject_out;
    logic [31:0] sender_out;
    logic [3:0]  kind_out;
    logic [31:0] event_id;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  kind;
    logic [31:0] sender;
    logic [31:0] subject;
    logic [47:0] position;
    logic [30:0] precision;
    logic [16:0] urgency;
    logic [47:0] issued;
    logic [47:0] expiry;
  } slot_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd;
    logic idx_clr;
    logic idx_inc;
    logic div_start;
    logic best_upd;
    logic sel_cur;
    logic sel_best;
    logic wr;
    logic emit_rej;
    logic emit_pub;
    logic col_take;
    logic emit_final;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_collect;
    logic in_reject;
    logic in_lim_zero;
    logic free;
    logic need_div;
    logic div_busy;
    logic live;
    logic pend_valid;
    logic cnt_hit;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/eet_div.sv @@
// bit-serial restoring divider for the age penalty
`default_nettype none
module eet_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [eet_pkg::QW-1:0] divisor,
  output logic                        busy,
  output logic [eet_pkg::QW-1:0]      quot
);
  import eet_pkg::*;

  logic [QW-1:0] r;
  logic [QW-1:0] q;
  logic [QW-1:0] d;
  logic [3:0]    cnt;
  logic [QW:0]   sh;
  logic          ge;
  logic [QW:0]   diff;

  // one quotient bit per cycle
  always_comb begin
    sh   = {r, q[QW-1]};
    ge   = sh >= {1'b0, d};
    diff = sh - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'(QW);
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r <= '0;
      q <= PENALTY_NUM;
      d <= divisor;
    end else if (busy) begin
      r <= ge ? diff[QW-1:0] : sh[QW-1:0];
      q <= {q[QW-2:0], ge};
    end
  end

  assign quot = q;
endmodule
`default_nettype wire

@@ hdl/eet_ctrl.sv @@
// controller state machine of the expiring event table
`default_nettype none
module eet_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire eet_pkg::sts_t sts,
  output eet_pkg::cmd_t      cmd
);
  import eet_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [8:0] {
    IDLE = 9'b000000001,
    REJ  = 9'b000000010,
    PRD  = 9'b000000100,
    PEV  = 9'b000001000,
    PDIV = 9'b000010000,
    PWR  = 9'b000100000,
    CRD  = 9'b001000000,
    CEV  = 9'b010000000,
    CFIN = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          cmd.idx_clr = 1'b1;
          if (sts.in_collect) begin
            state_next = sts.in_lim_zero ? CFIN : CRD;
          end else begin
            state_next = sts.in_reject ? REJ : PRD;
          end
        end
      end
      REJ: begin
        if (sts.out_free) begin
          cmd.emit_rej = 1'b1;
          state_next   = IDLE;
        end
      end
      PRD: begin
        cmd.rd     = 1'b1;
        state_next = PEV;
      end
      PEV: begin
        if (sts.free) begin
          cmd.sel_cur = 1'b1;
          state_next  = PWR;
        end else if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = PDIV;
        end else begin
          cmd.best_upd = 1'b1;
          if (sts.idx_last) begin
            cmd.sel_best = 1'b1;
            state_next   = PWR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = PRD;
          end
        end
      end
      PDIV: begin
        if (!sts.div_busy) begin
          cmd.best_upd = 1'b1;
          if (sts.idx_last) begin
            cmd.sel_best = 1'b1;
            state_next   = PWR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = PRD;
          end
        end
      end
      PWR: begin
        if (sts.out_free) begin
          cmd.wr       = 1'b1;
          cmd.emit_pub = 1'b1;
          state_next   = IDLE;
        end
      end
      CRD: begin
        cmd.rd     = 1'b1;
        state_next = CEV;
      end
      CEV: begin
        if (sts.live) begin
          if (!sts.pend_valid || sts.out_free) begin
            cmd.col_take = 1'b1;
            if (sts.cnt_hit || sts.idx_last) begin
              state_next = CFIN;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = CRD;
            end
          end
        end else if (sts.idx_last) begin
          state_next = CFIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = CRD;
        end
      end
      CFIN: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CHK_NEXT(a_accept_leaves_idle, accept, state != IDLE, "item accepted but controller stayed idle")
endmodule
`default_nettype wire

@@ hdl/eet_dp.sv @@
// datapath: slot memory, scan registers, penalty divider and result register
`default_nettype none
module eet_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [eet_pkg::IN_W-1:0]   in_data,
  input  wire logic                       in_user,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_addr,
  input  wire logic [31:0]                cfg_wdata,
  input  wire eet_pkg::cmd_t              cmd,
  output eet_pkg::sts_t                   sts,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [eet_pkg::OUT_W-1:0]       out_data,
  output logic                            out_user,
  output logic                            out_last
);
  import eet_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  in_item_t     in_w;
  in_item_t     in_r;
  logic         act_r;
  logic [31:0]  lifetime;
  logic [30:0]  min_prec;
  slot_t        mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  slot_t        rd_q;
  logic         rd_act;
  logic [IW-1:0] idx;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] sel;
  logic [17:0]  best_score;
  logic [31:0]  id_counter;
  logic [4:0]   cnt;
  out_item_t    pend;
  logic         pend_valid;
  logic         div_busy;
  logic [QW-1:0] quot;
  logic [47:0]  now;
  logic [47:0]  rem;
  logic         need_div;
  logic [17:0]  score;
  logic         take;
  logic [4:0]   lim;
  logic [48:0]  exp_sum;
  logic [47:0]  exp_n;
  logic [30:0]  prec_n;
  logic [16:0]  urg_n;
  logic [31:0]  id_use;
  slot_t        new_slot;
  out_item_t    rd_item;
  logic         out_free;
  logic         emit_any;

  assign in_w = in_item_t'(in_data);
  assign now  = in_r.tick;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFE_RESET;
      min_prec <= PREC_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LIFETIME: lifetime <= cfg_wdata;
        REG_MIN_PREC: min_prec <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r  <= in_w;
      act_r <= in_user;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[sel] <= new_slot;
    end
    if (cmd.rd) begin
      rd_q <= mem[idx];
    end
  end

  // per-slot active bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_act <= 1'b0;
    end else begin
      if (cmd.wr) begin
        valid[sel] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_act <= valid[idx];
      end
    end
  end

  // entry evaluation
  always_comb begin
    rem      = rd_q.expiry - now;
    need_div = (rem != 48'd0) && (rem < {36'd0, PENALTY_NUM});
    score    = {1'b0, rd_q.urgency} + (need_div ? {6'd0, quot} : 18'd0);
    take     = (idx == '0) || (score < best_score);
    lim      = (in_r.collect_limit > MAX_RES) ? MAX_RES : in_r.collect_limit;
  end

  eet_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .divisor (QW'(rem) + QW'(1)),
    .busy    (div_busy),
    .quot    (quot)
  );

  // scan index, best candidate, chosen slot, result count
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (cmd.best_upd && take) begin
      best_score <= score;
      best_idx   <= idx;
    end
    if (cmd.sel_cur) begin
      sel <= idx;
    end else if (cmd.sel_best) begin
      sel <= take ? idx : best_idx;
    end
    if (cmd.load_in) begin
      cnt <= '0;
    end else if (cmd.col_take) begin
      cnt <= cnt + 5'd1;
    end
  end

  // normalized fields of a new event
  always_comb begin
    exp_sum = {1'b0, now} + {17'd0, lifetime};
    if (in_r.expiry <= now) begin
      exp_n = exp_sum[48] ? '1 : exp_sum[47:0];
    end else begin
      exp_n = in_r.expiry;
    end
    if ($signed(in_r.precision) < $signed({1'b0, min_prec})) begin
      prec_n = min_prec;
    end else begin
      prec_n = in_r.precision[30:0];
    end
    if (in_r.urgency[17]) begin
      urg_n = '0;
    end else if (in_r.urgency[16:0] > URG_ONE) begin
      urg_n = URG_ONE;
    end else begin
      urg_n = in_r.urgency[16:0];
    end
    id_use             = (id_counter == 32'd0) ? 32'd1 : id_counter;
    new_slot.id        = id_use;
    new_slot.kind      = in_r.kind;
    new_slot.sender    = in_r.sender;
    new_slot.subject   = in_r.subject;
    new_slot.position  = in_r.position;
    new_slot.precision = prec_n;
    new_slot.urgency   = urg_n;
    new_slot.issued    = now;
    new_slot.expiry    = exp_n;
  end

  // id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= 32'd1;
    end else if (cmd.wr) begin
      id_counter <= id_use + 32'd1;
    end
  end

  // entry as a result item
  always_comb begin
    rd_item               = '0;
    rd_item.event_id      = rd_q.id;
    rd_item.kind_out      = rd_q.kind;
    rd_item.sender_out    = rd_q.sender;
    rd_item.subject_out   = rd_q.subject;
    rd_item.position_out  = rd_q.position;
    rd_item.precision_out = rd_q.precision;
    rd_item.urgency_out   = rd_q.urgency;
    rd_item.issued_out    = rd_q.issued;
    rd_item.expiry_out    = rd_q.expiry;
  end

  // pending collect item, held until the next live entry or the end
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.col_take) begin
      pend_valid <= 1'b1;
    end else if (cmd.emit_final) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_take) begin
      pend <= rd_item;
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;
  assign emit_any = cmd.emit_rej || cmd.emit_pub || cmd.emit_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_rej || cmd.emit_pub || cmd.emit_final
                 || (cmd.col_take && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rej) begin
      out_data <= '0;
      out_user <= 1'b0;
      out_last <= 1'b1;
    end else if (cmd.emit_pub) begin
      out_data <= OUT_W'({264'd0, id_use});
      out_user <= 1'b1;
      out_last <= 1'b1;
    end else if (cmd.col_take && pend_valid) begin
      out_data <= pend;
      out_user <= 1'b1;
      out_last <= 1'b0;
    end else if (cmd.emit_final) begin
      out_data <= pend_valid ? pend : '0;
      out_user <= pend_valid;
      out_last <= 1'b1;
    end
  end

  // status to the controller
  always_comb begin
    sts.in_collect  = (in_user == ACT_COLLECT);
    sts.in_reject   = (in_w.kind == 4'd0) || (in_w.sender == 32'd0);
    sts.in_lim_zero = (in_w.collect_limit == 5'd0);
    sts.free        = !rd_act || (rd_q.expiry < now);
    sts.need_div    = need_div;
    sts.div_busy    = div_busy;
    sts.live        = rd_act && (rd_q.issued <= now) && (now <= rd_q.expiry);
    sts.pend_valid  = pend_valid;
    sts.cnt_hit     = (cnt + 5'd1) == lim;
    sts.idx_last    = (idx == IW'(ENTRIES - 1));
    sts.out_free    = out_free;
  end

  `CHK_IMPL(a_push_needs_room, cmd.col_take && pend_valid, out_free, "push onto full output")
  `CHK_IMPL(a_emit_needs_room, emit_any, out_free, "result emitted onto full output")
  `CHK_NEXT(a_count_bound, cmd.col_take, cnt <= lim && act_r == ACT_COLLECT, "count over limit")
endmodule
`default_nettype wire

@@ hdl/expiring_event_table.sv @@
// Expiring event table: publish stores an event in a slot, collect streams live entries.
// Publish: each slot scanned is read (PRD) and evaluated (PEV), waiting in PDIV for an occupied slot
// whose remaining time is 1 to 3276 ticks (bit-serial penalty divider), then PWR; rejects use REJ.
// Collect: each slot scanned is read (CRD) and evaluated (CEV); one slot memory read port sets the pace.
// One item at a time, taken once the last result is in the output register; a held output adds its wait.
// Synchronous reset clears all slots, the id counter to one and the registers to defaults.
`default_nettype none
module expiring_event_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // kind, sender, subject, position, precision, urgency, tick, expiry, collect_limit
  input  wire logic [eet_pkg::IN_W-1:0] s_tdata,
  // action
  input  wire logic                     s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // event_id, kind_out, sender_out, subject_out, position_out, precision_out,
  // urgency_out, issued_out, expiry_out
  output logic [eet_pkg::OUT_W-1:0]     m_tdata,
  // ok
  output logic                          m_tuser,
  // last
  output logic                          m_tlast,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_addr,
  input  wire logic [31:0]              cfg_wdata
);
  import eet_pkg::*;

  cmd_t cmd;
  sts_t sts;

  eet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eet_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the expiring event table
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import eet_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic     act;
    in_item_t d;
  } request_t;

  typedef struct {
    logic      ok;
    out_item_t d;
    logic      last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [31:0] cfg_wdata = '0;

  expiring_event_table dut (.*);

  always #4 clk = ~clk;

  // table model kept by the testbench
  logic        tbl_active [NSLOT];
  slot_t       tbl_slot [NSLOT];
  logic [31:0] next_id;
  logic [31:0] lifetime;
  logic [30:0] prec_floor;

  request_t pending_items[$];
  result_t  expected_results[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  publishes_sent = 0;
  int  collects_sent = 0;
  int  cycles = 0;
  bit  steady = 1'b0;
  int  hold_requests = 0;
  int  holds_served = 0;
  logic [47:0] tick_base = 48'd100;

  // choose the slot a new event goes to
  function automatic int pick_victim(logic [47:0] t);
    int best;
    longint unsigned best_score, pen, score;
    best = 0;
    best_score = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_active[i] || tbl_slot[i].expiry < t) return i;
      pen = 0;
      if (tbl_slot[i].expiry > t)
        pen = 64'd3277 / (64'd1 + longint'(tbl_slot[i].expiry - t));
      score = longint'(tbl_slot[i].urgency) + pen;
      if (i == 0 || score < best_score) begin
        best_score = score;
        best = i;
      end
    end
    return best;
  endfunction

  // update the table and queue the results of one accepted item
  task automatic apply_item(request_t r);
    result_t res;
    logic [48:0] sum;
    logic [47:0] ex;
    logic signed [32:0] prec;
    logic signed [17:0] urg;
    int s, lim, cnt;
    res.ok = 1'b0;
    res.d = '0;
    res.last = 1'b1;
    if (r.act == ACT_PUBLISH) begin
      if (r.d.kind != 0 && r.d.sender != 0) begin
        if (next_id == 0) next_id = 1;
        res.ok = 1'b1;
        res.d.event_id = next_id;
        next_id = next_id + 1;
        ex = r.d.expiry;
        if (ex <= r.d.tick) begin
          sum = {1'b0, r.d.tick} + {17'd0, lifetime};
          ex = sum[48] ? TICK_MAX : sum[47:0];
        end
        prec = $signed({r.d.precision[31], r.d.precision});
        if (prec < $signed({2'b00, prec_floor})) prec = $signed({2'b00, prec_floor});
        urg = $signed(r.d.urgency);
        s = pick_victim(r.d.tick);
        tbl_active[s] = 1'b1;
        tbl_slot[s].id = res.d.event_id;
        tbl_slot[s].kind = r.d.kind;
        tbl_slot[s].sender = r.d.sender;
        tbl_slot[s].subject = r.d.subject;
        tbl_slot[s].position = r.d.position;
        tbl_slot[s].precision = prec[30:0];
        if (urg < 0) tbl_slot[s].urgency = 17'd0;
        else if (urg > 18'sd65536) tbl_slot[s].urgency = URG_ONE;
        else tbl_slot[s].urgency = urg[16:0];
        tbl_slot[s].issued = r.d.tick;
        tbl_slot[s].expiry = ex;
      end
      expected_results.push_back(res);
    end else begin
      lim = (r.d.collect_limit > MAX_RES) ? int'(MAX_RES) : int'(r.d.collect_limit);
      cnt = 0;
      for (int i = 0; i < NSLOT && cnt < lim; i++) begin
        if (tbl_active[i] && r.d.tick >= tbl_slot[i].issued
            && r.d.tick <= tbl_slot[i].expiry) begin
          res.ok = 1'b1;
          res.last = 1'b0;
          res.d = '0;
          res.d.event_id = tbl_slot[i].id;
          res.d.kind_out = tbl_slot[i].kind;
          res.d.sender_out = tbl_slot[i].sender;
          res.d.subject_out = tbl_slot[i].subject;
          res.d.position_out = tbl_slot[i].position;
          res.d.precision_out = tbl_slot[i].precision;
          res.d.urgency_out = tbl_slot[i].urgency;
          res.d.issued_out = tbl_slot[i].issued;
          res.d.expiry_out = tbl_slot[i].expiry;
          expected_results.push_back(res);
          cnt++;
        end
      end
      if (cnt == 0) begin
        res.ok = 1'b0;
        res.d = '0;
        res.last = 1'b1;
        expected_results.push_back(res);
      end else begin
        expected_results[$].last = 1'b1;
      end
    end
  endtask

  // driver: offers queued items with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    logic nv;
    request_t r;
    cycles <= cycles + 1;
    if (!rst) begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        r = pending_items.pop_front();
        apply_item(r);
        if (r.act == ACT_PUBLISH) publishes_sent++; else collects_sent++;
        nv = 1'b0;
        send_gap = steady ? 0 : $urandom_range(0, 9);
      end
      if (!nv && pending_items.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          nv = 1'b1;
          s_tdata <= pending_items[0].d;
          s_tuser <= pending_items[0].act;
        end
      end
      s_tvalid <= nv;
    end
  end

  // monitor: compares each result with the oldest expectation
  int take_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    out_item_t got;
    result_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ok=%0d id=%0h last=%0d", m_tuser, got.event_id,
                     m_tlast);
        end else begin
          e = expected_results.pop_front();
          if (m_tuser !== e.ok || m_tlast !== e.last || got.event_id !== e.d.event_id
              || got.kind_out !== e.d.kind_out || got.sender_out !== e.d.sender_out
              || got.subject_out !== e.d.subject_out
              || got.position_out !== e.d.position_out
              || got.precision_out !== e.d.precision_out
              || got.urgency_out !== e.d.urgency_out
              || got.issued_out !== e.d.issued_out || got.expiry_out !== e.d.expiry_out
              || got.pad !== e.d.pad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp ok=%0d last=%0d id=%0h kind=%0h snd=%0h subj=%0h",
                       e.ok, e.last, e.d.event_id, e.d.kind_out, e.d.sender_out,
                       e.d.subject_out);
              $display("          got ok=%0d last=%0d id=%0h kind=%0h snd=%0h subj=%0h",
                       m_tuser, m_tlast, got.event_id, got.kind_out, got.sender_out,
                       got.subject_out);
              $display("  exp pos=%0h prec=%0h urg=%0h iss=%0h exp=%0h", e.d.position_out,
                       e.d.precision_out, e.d.urgency_out, e.d.issued_out,
                       e.d.expiry_out);
              $display("  got pos=%0h prec=%0h urg=%0h iss=%0h exp=%0h", got.position_out,
                       got.precision_out, got.urgency_out, got.issued_out,
                       got.expiry_out);
            end
          end
        end
        take_gap = steady ? 0 : $urandom_range(0, 9);
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = 600;
      end
      if (hold_left > 0) hold_left--;
      else if (take_gap > 0 && !(m_tvalid && m_tready)) take_gap--;
      m_tready <= (hold_left == 0 && take_gap == 0 && !(m_tvalid && m_tready && !steady));
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic request_t make_publish(bit good);
    request_t r;
    r.act = ACT_PUBLISH;
    r.d = '0;
    r.d.kind = good ? 4'($urandom_range(1, 15)) : 4'($urandom());
    r.d.sender = good ? ($urandom() | 32'd1 << $urandom_range(0, 31)) : $urandom();
    if (!good && $urandom_range(0, 1)) r.d.sender = 0;
    r.d.subject = $urandom();
    r.d.position = rand48();
    r.d.precision = $urandom();
    r.d.urgency = 18'($urandom());
    if ($urandom_range(0, 3) == 0) r.d.urgency = 18'($urandom_range(0, 65536));
    r.d.tick = ($urandom_range(0, 15) == 0) ? rand48() : tick_base + $urandom_range(0, 20);
    case ($urandom_range(0, 7))
      0, 1: r.d.expiry = r.d.tick - $urandom_range(0, 3);
      2: r.d.expiry = rand48();
      3: r.d.expiry = r.d.tick + $urandom_range(1, 4);
      default: r.d.expiry = r.d.tick + $urandom_range(1, 5000);
    endcase
    r.d.collect_limit = 5'($urandom());
    r.d.pad = 5'($urandom());
    return r;
  endfunction

  function automatic request_t make_collect();
    request_t r;
    request_t p;
    p = make_publish(1'b0);
    r.act = ACT_COLLECT;
    r.d = p.d;
    r.d.tick = ($urandom_range(0, 15) == 0) ? rand48()
             : tick_base + $urandom_range(0, 300) - 30;
    r.d.collect_limit = ($urandom_range(0, 4) == 0) ? 5'($urandom())
                      : 5'($urandom_range(1, 16));
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    if (idx == REG_LIFETIME) lifetime = v;
    else prec_floor = v[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_directed(logic act, logic [3:0] k, logic [31:0] snd,
                               logic [31:0] pr, logic [17:0] ur, logic [47:0] tk,
                               logic [47:0] ex, logic [4:0] lim);
    request_t r;
    r = make_publish(1'b1);
    r.act = act;
    r.d.kind = k;
    r.d.sender = snd;
    r.d.precision = pr;
    r.d.urgency = ur;
    r.d.tick = tk;
    r.d.expiry = ex;
    r.d.collect_limit = lim;
    pending_items.push_back(r);
  endtask

  // stimulus, phase by phase
  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_active[i] = 1'b0;
      tbl_slot[i] = '0;
    end
    next_id = 1;
    lifetime = LIFE_RESET;
    prec_floor = PREC_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_LIFETIME, 32'd180);
    write_reg(REG_MIN_PREC, 32'd65536);

    // directed: rejects, field extremes, defaulted expiry, clamps, collect limits
    push_directed(ACT_COLLECT, 1, 1, 0, 0, 48'd50, 0, 5'd16);
    push_directed(ACT_PUBLISH, 0, 32'h1234, 0, 0, 48'd100, 48'd200, 0);
    push_directed(ACT_PUBLISH, 4'd3, 0, 0, 0, 48'd100, 48'd200, 0);
    push_directed(ACT_PUBLISH, 4'd15, 32'hFFFF_FFFF, 32'h8000_0000, 18'h20000,
                  48'd100, 48'd100, 0);
    push_directed(ACT_PUBLISH, 4'd1, 32'd1, 32'h7FFF_FFFF, 18'h1FFFF, 48'd100, 48'd40, 0);
    push_directed(ACT_PUBLISH, 4'd2, 32'd7, 32'd0, 18'd65536, 48'd110, 48'd111, 0);
    push_directed(ACT_PUBLISH, 4'd4, 32'd9, 32'hFFFF_FFFF, 18'd65535, 48'd120, TICK_MAX, 0);
    push_directed(ACT_PUBLISH, 4'd5, 32'd9, 32'd65535, 18'd0,
                  48'hFFFF_FFFF_FFA0, 48'd0, 0);
    push_directed(ACT_COLLECT, 0, 0, 0, 0, 48'd111, 0, 5'd0);
    push_directed(ACT_COLLECT, 0, 0, 0, 0, 48'd111, 0, 5'd16);
    push_directed(ACT_COLLECT, 0, 0, 0, 0, 48'd111, 0, 5'd31);
    push_directed(ACT_COLLECT, 0, 0, 0, 0, 48'd111, 0, 5'd1);
    push_directed(ACT_COLLECT, 0, 0, 0, 0, 48'd112, 0, 5'd17);
    push_directed(ACT_COLLECT, 0, 0, 0, 0, 48'd99, 0, 5'd16);
    push_directed(ACT_COLLECT, 0, 0, 0, 0, TICK_MAX, 0, 5'd16);
    drain();

    // random phases under different register settings
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 1) begin
        write_reg(REG_LIFETIME, 32'd0);
        write_reg(REG_MIN_PREC, 32'd0);
      end else if (ph == 2) begin
        write_reg(REG_LIFETIME, 32'hFFFF_FFFF);
        write_reg(REG_MIN_PREC, 32'h7FFF_FFFF);
      end else if (ph >= 3) begin
        write_reg(REG_LIFETIME, $urandom_range(1, 400));
        write_reg(REG_MIN_PREC, $urandom());
      end
      steady = (ph == 3);
      for (int n = 0; n < 40; n++) begin
        case ($urandom_range(0, 9))
          0: pending_items.push_back(make_publish(1'b0));
          1, 2, 3: pending_items.push_back(make_collect());
          default: pending_items.push_back(make_publish(1'b1));
        endcase
        tick_base = tick_base + $urandom_range(0, 15);
      end
      // stall the receiver while collects pile up behind it
      if (ph == 2) begin
        for (int n = 0; n < 6; n++) pending_items.push_back(make_collect());
        hold_requests++;
      end
      drain();
    end

    $display("sent %0d publishes and %0d collects, checked %0d results",
             publishes_sent, collects_sent, results_seen);
    $display("covered rejects, defaulted expiry, clamping, replacement and limits");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
